// ===== hdl/xr_pkg.sv =====
// Shared types, link byte codes and the CRC-16 byte update for the XMODEM receiver.
package xr_pkg;

  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);

  localparam logic [7:0] BYTE_SOH  = 8'h01;
  localparam logic [7:0] BYTE_EOT  = 8'h04;
  localparam logic [7:0] BYTE_ACK  = 8'h06;
  localparam logic [7:0] BYTE_NAK  = 8'h15;
  localparam logic [7:0] BYTE_CAN  = 8'h18;
  localparam logic [7:0] BYTE_C    = 8'h43;
  localparam logic [7:0] BYTE_FILL = 8'h1A;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TRIES = 1'd1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  localparam logic [1:0] STAT_RUNNING = 2'd0;
  localparam logic [1:0] STAT_EOT     = 2'd1;
  localparam logic [1:0] STAT_CAN     = 2'd2;
  localparam logic [1:0] STAT_NO_SOH  = 2'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       block_end;
    logic       block_good;
    logic [1:0] session_status;
  } out_item_t;

  // Classified link item handed from the front to the back.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       is_soh;
    logic       is_eot;
    logic       is_can;
    logic       is_fill;
  } cls_item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hdl/xr_front.sv =====
// Front end: accepts link items, classifies the byte and queues them for the back end.
module xr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  xr_pkg::in_item_t     item_i,
  output logic                 cls_valid_o,
  output xr_pkg::cls_item_t    cls_o,
  input  logic                 cls_take_i
);

  xr_pkg::cls_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  xr_pkg::cls_item_t cls_new;

  always_comb begin
    cls_new.func    = item_i.func;
    cls_new.rx_byte = item_i.rx_byte;
    cls_new.is_soh  = (item_i.rx_byte == xr_pkg::BYTE_SOH);
    cls_new.is_eot  = (item_i.rx_byte == xr_pkg::BYTE_EOT);
    cls_new.is_can  = (item_i.rx_byte == xr_pkg::BYTE_CAN);
    cls_new.is_fill = (item_i.rx_byte == xr_pkg::BYTE_FILL);
  end

  assign full        = (cnt_q == 2'd2);
  assign cls_valid_o = (cnt_q != 2'd0);
  assign cls_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cls_take_i && cls_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls_new;
    end
  end

endmodule

// ===== hdl/xr_back.sv =====
// Back end: session state machine, block check and result queue.
module xr_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [xr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [xr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                             cls_valid_i,
  input  xr_pkg::cls_item_t                cls_i,
  output logic                             cls_take_o,
  output logic                             empty,
  input  logic                             pop,
  output xr_pkg::out_item_t                out_item_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WAIT  = 3'd1;
  localparam logic [2:0] PH_NUM   = 3'd2;
  localparam logic [2:0] PH_COMP  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHK1  = 3'd5;
  localparam logic [2:0] PH_CHK2  = 3'd6;
  localparam logic [2:0] PH_AFTER = 3'd7;

  localparam logic [xr_pkg::POS_W-1:0] POS_LAST = xr_pkg::POS_W'(xr_pkg::BLOCK_BYTES - 1);

  logic                     crc_mode_q;
  logic [3:0]               tries_max_q;
  logic [2:0]               phase_q, phase_d;
  logic [3:0]               tries_q, tries_d;
  logic [7:0]               num_q, num_d;
  logic [7:0]               comp_q, comp_d;
  logic [xr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]              crc_q, crc_d;
  logic [7:0]               sum_q, sum_d;
  logic [7:0]               crc_hi_q, crc_hi_d;
  logic [1:0]               status_q, status_d;

  xr_pkg::out_item_t res;
  logic       verdict, good, num_ok;
  logic [7:0] start_byte;
  logic [7:0] b;

  xr_pkg::out_item_t oq_q [2];
  logic       oq_wr_q, oq_rd_q;
  logic [1:0] oq_cnt_q;
  logic       take, oq_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q  <= 1'b1;
      tries_max_q <= 4'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xr_pkg::CFG_CRC_MODE:    crc_mode_q  <= cfg_data_i[0];
        xr_pkg::CFG_START_TRIES: tries_max_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign take   = cls_valid_i && (oq_cnt_q != 2'd2);
  assign oq_pop = pop && (oq_cnt_q != 2'd0);
  assign cls_take_o = take;

  assign b          = cls_i.rx_byte;
  assign num_ok     = ((num_q ^ comp_q) == 8'hFF);
  assign start_byte = crc_mode_q ? xr_pkg::BYTE_C : xr_pkg::BYTE_NAK;

  always_comb begin
    phase_d  = phase_q;
    tries_d  = tries_q;
    num_d    = num_q;
    comp_d   = comp_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    sum_d    = sum_q;
    crc_hi_d = crc_hi_q;
    status_d = status_q;
    verdict  = 1'b0;
    good     = 1'b0;
    res      = '0;

    if (cls_i.func == xr_pkg::FUNC_START) begin
      status_d     = xr_pkg::STAT_RUNNING;
      tries_d      = 4'd1;
      phase_d      = PH_WAIT;
      res.tx_valid = 1'b1;
      res.tx_byte  = start_byte;
    end else begin
      case (phase_q)
        PH_WAIT: begin
          if (cls_i.is_soh) begin
            phase_d = PH_NUM;
          end else if (tries_q >= tries_max_q) begin
            phase_d  = PH_IDLE;
            status_d = xr_pkg::STAT_NO_SOH;
          end else begin
            tries_d      = tries_q + 4'd1;
            res.tx_valid = 1'b1;
            res.tx_byte  = start_byte;
          end
        end
        PH_NUM: begin
          num_d   = b;
          phase_d = PH_COMP;
        end
        PH_COMP: begin
          comp_d  = b;
          pos_d   = '0;
          crc_d   = 16'h0000;
          sum_d   = 8'h00;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          crc_d = xr_pkg::crc16_byte(crc_q, b);
          sum_d = sum_q + b;
          if (!cls_i.is_fill) begin
            res.data_valid = 1'b1;
            res.data_byte  = b;
          end
          if (pos_q == POS_LAST) begin
            pos_d   = '0;
            phase_d = PH_CHK1;
          end else begin
            pos_d = pos_q + xr_pkg::POS_W'(1);
          end
        end
        PH_CHK1: begin
          if (crc_mode_q) begin
            crc_hi_d = b;
            phase_d  = PH_CHK2;
          end else begin
            verdict = 1'b1;
            good    = num_ok && (b == sum_q);
          end
        end
        PH_CHK2: begin
          verdict = 1'b1;
          good    = num_ok && ({crc_hi_q, b} == crc_q);
        end
        PH_AFTER: begin
          if (cls_i.is_eot || cls_i.is_can) begin
            status_d     = cls_i.is_eot ? xr_pkg::STAT_EOT : xr_pkg::STAT_CAN;
            phase_d      = PH_IDLE;
            res.tx_valid = 1'b1;
            res.tx_byte  = xr_pkg::BYTE_ACK;
          end else begin
            phase_d = PH_NUM;
          end
        end
        default: ;
      endcase
      if (verdict) begin
        res.block_end  = 1'b1;
        res.block_good = good;
        res.tx_valid   = 1'b1;
        res.tx_byte    = good ? xr_pkg::BYTE_ACK : xr_pkg::BYTE_NAK;
        phase_d        = PH_AFTER;
      end
    end
    res.session_status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tries_q  <= 4'd0;
      num_q    <= 8'h00;
      comp_q   <= 8'h00;
      pos_q    <= '0;
      crc_q    <= 16'h0000;
      sum_q    <= 8'h00;
      crc_hi_q <= 8'h00;
      status_q <= xr_pkg::STAT_RUNNING;
    end else if (take) begin
      phase_q  <= phase_d;
      tries_q  <= tries_d;
      num_q    <= num_d;
      comp_q   <= comp_d;
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      sum_q    <= sum_d;
      crc_hi_q <= crc_hi_d;
      status_q <= status_d;
    end
  end

  // Result queue: two entries so a stalled result does not stop the next transfer
  assign empty      = (oq_cnt_q == 2'd0);
  assign out_item_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (take) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
      oq_cnt_q <= oq_cnt_q + 2'(take) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_data_in_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && res.data_valid) |-> (phase_q == PH_DATA))
    else $error("payload byte emitted outside data phase");

  a_last_byte_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cls_i.func == xr_pkg::FUNC_BYTE && phase_q == PH_DATA && pos_q == POS_LAST)
    |=> (phase_q == PH_CHK1))
    else $error("last data byte did not advance to check phase");

  a_verdict_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && res.block_end) |=> (phase_q == PH_AFTER && oq_cnt_q != 2'd0))
    else $error("block verdict not followed by after-block phase");

endmodule

// ===== hdl/xmodem_receiver.sv =====
// XMODEM receiver top level: front classifier queue feeding the session back end.
// Path: an item is registered in the front queue, then its result in the result queue, where it waits for pop.
// Throughput: one item per cycle while neither queue is full; the back end's byte-wide CRC update sets that rate.
// Each side holds a two-entry queue, so push and pop may stall independently.
// Reset (rst_ni low, asynchronous) empties both queues, puts the session idle with
// status running, and sets crc_mode to 1 and start_tries to 6.
module xmodem_receiver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  xr_pkg::in_item_t                 in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output xr_pkg::out_item_t                out_item_o,
  input  logic                             cfg_we_i,
  input  logic [xr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [xr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic              cls_valid;
  logic              cls_take;
  xr_pkg::cls_item_t cls_item;

  xr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (in_item_i),
    .cls_valid_o (cls_valid),
    .cls_o       (cls_item),
    .cls_take_i  (cls_take)
  );

  xr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cls_valid_i (cls_valid),
    .cls_i       (cls_item),
    .cls_take_o  (cls_take),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/xmodem_receiver_tb.sv =====
// Self-checking testbench for the XMODEM receiver: session stimulus, reply prediction, scoreboard.
module xmodem_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xr_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_NUM, PH_COMP, PH_DATA, PH_CHK1, PH_CHK2, PH_AFTER
  } link_phase_e;

  typedef enum int {
    BLK_GOOD, BLK_BAD_NUM, BLK_BAD_CHECK, BLK_FLIP_MODE, BLK_ABORT
  } block_kind_e;

  // Tracks the receiver session and holds the replies still owed by the block.
  class reply_scoreboard;
    logic        crc_mode;
    logic [3:0]  start_tries;
    link_phase_e phase;
    logic [3:0]  tries_used;
    logic [7:0]  blk_num;
    logic [7:0]  blk_cmp;
    int unsigned pos;
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [7:0]  crc_hi;
    logic [1:0]  status;
    out_item_t   replies_due[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned verdicts;
    int unsigned good_blocks;

    function new();
      crc_mode    = 1'b1;
      start_tries = 4'd6;
      phase       = PH_IDLE;
      tries_used  = '0;
      blk_num     = '0;
      blk_cmp     = '0;
      pos         = 0;
      crc         = '0;
      sum         = '0;
      crc_hi      = '0;
      status      = STAT_RUNNING;
      errors      = 0;
      checked     = 0;
      verdicts    = 0;
      good_blocks = 0;
    endfunction

    static function logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
        if (r[15] ^ b[i]) r = (r << 1) ^ 16'h1021;
        else r = r << 1;
      end
      return r;
    endfunction

    function void report(input string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function logic [7:0] start_byte();
      return crc_mode ? BYTE_C : BYTE_NAK;
    endfunction

    function out_item_t predict_reply(input in_item_t it);
      out_item_t  r;
      logic       verdict;
      logic       good;
      logic [7:0] b;
      r       = '0;
      verdict = 1'b0;
      good    = 1'b0;
      b       = it.rx_byte;
      if (it.func == FUNC_START) begin
        status     = STAT_RUNNING;
        tries_used = 4'd1;
        phase      = PH_WAIT;
        r.tx_valid = 1'b1;
        r.tx_byte  = start_byte();
      end else begin
        case (phase)
          PH_WAIT: begin
            if (b == BYTE_SOH) begin
              phase = PH_NUM;
            end else if (tries_used >= start_tries) begin
              phase  = PH_IDLE;
              status = STAT_NO_SOH;
            end else begin
              tries_used++;
              r.tx_valid = 1'b1;
              r.tx_byte  = start_byte();
            end
          end
          PH_NUM: begin
            blk_num = b;
            phase   = PH_COMP;
          end
          PH_COMP: begin
            blk_cmp = b;
            pos     = 0;
            crc     = '0;
            sum     = '0;
            phase   = PH_DATA;
          end
          PH_DATA: begin
            crc = crc_step(crc, b);
            sum = sum + b;
            // fill bytes still feed the check but are not payload
            if (b != BYTE_FILL) begin
              r.data_valid = 1'b1;
              r.data_byte  = b;
            end
            pos++;
            if (pos >= BLOCK_BYTES) begin
              pos   = 0;
              phase = PH_CHK1;
            end
          end
          PH_CHK1: begin
            if (crc_mode) begin
              crc_hi = b;
              phase  = PH_CHK2;
            end else begin
              verdict = 1'b1;
              good    = ((blk_num ^ blk_cmp) == 8'hFF) && (b == sum);
            end
          end
          PH_CHK2: begin
            verdict = 1'b1;
            good    = ((blk_num ^ blk_cmp) == 8'hFF) && ({crc_hi, b} == crc);
          end
          PH_AFTER: begin
            if (b == BYTE_EOT || b == BYTE_CAN) begin
              status     = (b == BYTE_EOT) ? STAT_EOT : STAT_CAN;
              phase      = PH_IDLE;
              r.tx_valid = 1'b1;
              r.tx_byte  = BYTE_ACK;
            end else begin
              // any other byte is the header of the next block
              phase = PH_NUM;
            end
          end
          default: ;
        endcase
        if (verdict) begin
          verdicts++;
          if (good) good_blocks++;
          r.block_end  = 1'b1;
          r.block_good = good;
          r.tx_valid   = 1'b1;
          r.tx_byte    = good ? BYTE_ACK : BYTE_NAK;
          phase        = PH_AFTER;
        end
      end
      r.session_status = status;
      return r;
    endfunction

    function void note_item(input in_item_t it);
      replies_due.push_back(predict_reply(it));
    endfunction

    function void cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d field %s: got %h, want %h", checked, name, got, want));
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = replies_due.pop_front();
      cmp_field("tx_valid", got.tx_valid, want.tx_valid);
      cmp_field("tx_byte", got.tx_byte, want.tx_byte);
      cmp_field("data_valid", got.data_valid, want.data_valid);
      cmp_field("data_byte", got.data_byte, want.data_byte);
      cmp_field("block_end", got.block_end, want.block_end);
      cmp_field("block_good", got.block_good, want.block_good);
      cmp_field("session_status", got.session_status, want.session_status);
      checked++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  in_item_t              in_item;
  logic                  empty;
  logic                  pop;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  reply_scoreboard sb;
  bit              calm;
  int unsigned     items_sent;
  int unsigned     settings;
  int unsigned     pop_hold;

  xmodem_receiver uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check each transfer, stall pop in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_item);
    if (pop_hold != 0) pop_hold--;
    else if (!calm && $urandom_range(0, 11) == 0) pop_hold = $urandom_range(1, 17);
    pop <= (pop_hold == 0);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send(input logic f, input logic [7:0] b);
    in_item_t it;
    it.func    = f;
    it.rx_byte = b;
    if (!calm && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
    items_sent++;
  endtask

  // Hold off the sender until every owed result has been taken.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_config(input logic mode, input logic [3:0] tries);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CRC_MODE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk_i);
    cfg_idx  <= CFG_START_TRIES;
    cfg_data <= tries;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.crc_mode    = mode;
    sb.start_tries = tries;
    settings++;
  endtask

  function automatic logic [7:0] any_but_soh();
    logic [7:0] b;
    do b = 8'($urandom); while (b == BYTE_SOH);
    return b;
  endfunction

  task automatic send_block(input logic [7:0] hdr, input block_kind_e kind);
    logic [7:0]  num;
    logic [7:0]  b;
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [15:0] spoil;
    int unsigned fill_pct;
    int unsigned stop_at;
    num      = 8'($urandom);
    crc      = '0;
    sum      = '0;
    spoil    = (kind == BLK_BAD_CHECK) ? (16'h1 << $urandom_range(0, 15)) : '0;
    stop_at  = $urandom_range(0, BLOCK_BYTES - 1);
    case ($urandom_range(0, 3))
      0:       fill_pct = 60;
      1:       fill_pct = 10;
      default: fill_pct = 0;
    endcase
    send(FUNC_BYTE, hdr);
    send(FUNC_BYTE, num);
    if (kind == BLK_BAD_NUM) send(FUNC_BYTE, ~num ^ (8'h1 << $urandom_range(0, 7)));
    else send(FUNC_BYTE, ~num);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (kind == BLK_ABORT && i == stop_at) return;
      b = ($urandom_range(0, 99) < fill_pct) ? BYTE_FILL : 8'($urandom);
      send(FUNC_BYTE, b);
      crc = reply_scoreboard::crc_step(crc, b);
      sum = sum + b;
    end
    // switch the check format while the block waits for its check bytes
    if (kind == BLK_FLIP_MODE) begin
      drain();
      write_config(~sb.crc_mode, sb.start_tries);
    end
    if (sb.crc_mode) begin
      crc = crc ^ spoil;
      send(FUNC_BYTE, crc[15:8]);
      send(FUNC_BYTE, crc[7:0]);
    end else begin
      send(FUNC_BYTE, sum ^ spoil[7:0] ^ spoil[15:8]);
    end
  endtask

  task automatic run_session();
    int unsigned junk;
    int unsigned blocks;
    int unsigned pick;
    logic [7:0]  hdr;
    block_kind_e kind;
    send(FUNC_START, 8'($urandom));
    junk = $urandom_range(0, 3);
    if (sb.start_tries <= 1) junk = 0;
    else if (junk > sb.start_tries - 1) junk = sb.start_tries - 1;
    repeat (junk) send(FUNC_BYTE, any_but_soh());
    blocks = $urandom_range(1, 3);
    for (int k = 0; k < blocks; k++) begin
      hdr = BYTE_SOH;
      if (k != 0 && $urandom_range(0, 3) == 0)
        do hdr = 8'($urandom); while (hdr == BYTE_EOT || hdr == BYTE_CAN);
      pick = $urandom_range(0, 9);
      case (pick)
        5:       kind = BLK_BAD_NUM;
        6:       kind = BLK_BAD_CHECK;
        7:       kind = BLK_FLIP_MODE;
        8:       kind = BLK_ABORT;
        default: kind = BLK_GOOD;
      endcase
      send_block(hdr, kind);
      if (kind == BLK_ABORT) return;
    end
    case ($urandom_range(0, 3))
      0: send(FUNC_BYTE, BYTE_EOT);
      1: send(FUNC_BYTE, BYTE_CAN);
      2: ;
      default: begin
        send(FUNC_BYTE, BYTE_EOT);
        send(FUNC_BYTE, 8'($urandom));
      end
    endcase
  endtask

  initial begin
    logic [3:0] tries;
    sb         = new();
    calm       = 1'b0;
    items_sent = 0;
    settings   = 0;
    pop_hold   = 0;
    rst_ni   <= 1'b0;
    push     <= 1'b0;
    in_item  <= '0;
    pop      <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle bytes, start retries up to the give-up, start while busy
    send(FUNC_BYTE, 8'h00);
    send(FUNC_BYTE, 8'hFF);
    send(FUNC_START, 8'hFF);
    send(FUNC_BYTE, 8'h00);
    send(FUNC_BYTE, 8'hFF);
    send(FUNC_BYTE, BYTE_C);
    send(FUNC_BYTE, BYTE_NAK);
    send(FUNC_BYTE, BYTE_CAN);
    send(FUNC_BYTE, BYTE_EOT);
    send(FUNC_BYTE, BYTE_SOH);
    send(FUNC_START, 8'h00);
    send(FUNC_BYTE, BYTE_SOH);
    send(FUNC_BYTE, 8'h7E);
    send(FUNC_START, 8'h5A);
    // zero tries still sends one start byte, then gives up on the first miss
    drain();
    write_config(1'b0, 4'd0);
    send(FUNC_START, 8'hA5);
    send(FUNC_BYTE, 8'h55);
    drain();
    write_config(1'b1, 4'd1);
    send(FUNC_START, 8'h3C);
    send(FUNC_BYTE, BYTE_ACK);
    send(FUNC_BYTE, BYTE_FILL);

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent > ITEM_TARGET * 4 / 5);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       tries = 4'd1;
          1:       tries = 4'd15;
          default: tries = 4'($urandom_range(1, 15));
        endcase
        drain();
        write_config(1'($urandom_range(0, 1)), tries);
      end
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 8))
             send(($urandom_range(0, 5) == 0) ? FUNC_START : FUNC_BYTE, 8'($urandom));
        1: begin
          send(FUNC_START, 8'($urandom));
          repeat ((sb.start_tries == 0) ? 1 : sb.start_tries) send(FUNC_BYTE, any_but_soh());
        end
        default: run_session();
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d items over %0d register settings, %0d results checked",
             items_sent, settings, sb.checked);
    $display("block verdicts: %0d, of which %0d good", sb.verdicts, sb.good_blocks);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/xr_pkg.sv
hdl/xr_front.sv
hdl/xr_back.sv
hdl/xmodem_receiver.sv
tb/xmodem_receiver_tb.sv
